// ===== design/tgarle_pkg.sv =====
// ---------------------------------------------------------------------------
// TGA run-length decoder package
// Shared types and constants for the run-length pixel decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PIXEL_W       = 32;
  localparam int unsigned COUNT_W       = 8;
  localparam int unsigned DIM_W         = 16;
  localparam int unsigned TOTAL_W       = 2 * DIM_W;
  localparam int unsigned PB_W          = 3;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = DIM_W;

  localparam logic [BYTE_W-1:0]  REPEAT_FLAG_BYTE = 8'd128;
  localparam logic [BYTE_W-1:0]  REPEAT_BIAS      = 8'd127;
  localparam logic [PB_W-1:0]    PB_MAX           = 3'd4;
  localparam logic [PB_W-1:0]    PB_RESET         = 3'd4;
  localparam logic [DIM_W-1:0]   DIM_RESET        = 16'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    PH_HEADER,
    PH_PIXEL
  } phase_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               end_pkt;
  } pix_tok_t;

endpackage

`default_nettype wire

// ===== design/tgarle_front.sv =====
// ---------------------------------------------------------------------------
// TGA run-length decoder front end
// Parses packet headers and gathers pixel bytes into pixel requests.
// ---------------------------------------------------------------------------
`default_nettype none

module tgarle_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [tgarle_pkg::PB_W-1:0] pixel_bytes,
  input  wire logic                        byte_valid,
  input  wire logic [7:0]                  byte_data,
  output logic                             byte_stall,
  output logic                             tok_push,
  output tgarle_pkg::pix_tok_t             tok_data,
  input  wire logic                        tok_full
);
  import tgarle_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic                repeat_r, repeat_nxt;
  logic [COUNT_W-1:0]  left_r, left_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic [PIXEL_W-1:0]  gather_r, gather_nxt;

  logic                accept;
  logic [PB_W-1:0]     eff_pb;
  logic [1:0]          last_idx;
  logic                last_byte;
  logic [PIXEL_W-1:0]  merged;
  logic                pkt_end;

  assign byte_stall = tok_full;
  assign accept     = byte_valid && !tok_full;

  always_comb begin
    if (pixel_bytes == '0) begin
      eff_pb = 3'd1;
    end else if (pixel_bytes > PB_MAX) begin
      eff_pb = PB_MAX;
    end else begin
      eff_pb = pixel_bytes;
    end
  end

  assign last_idx  = 2'(eff_pb - 3'd1);
  assign last_byte = (idx_r >= last_idx);
  assign merged    = gather_r | ({{(PIXEL_W-BYTE_W){1'b0}}, byte_data} << {idx_r, 3'b000});
  assign pkt_end   = repeat_r || (left_r == 8'd1);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (accept) phase_nxt = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (accept && last_byte && pkt_end) phase_nxt = PH_HEADER;
      end
      default: phase_nxt = PH_HEADER;
    endcase
  end

  always_comb begin
    repeat_nxt = repeat_r;
    left_nxt   = left_r;
    idx_nxt    = idx_r;
    gather_nxt = gather_r;
    tok_push   = 1'b0;
    unique case (phase_r)
      PH_HEADER: begin
        if (accept) begin
          if (byte_data < REPEAT_FLAG_BYTE) begin
            repeat_nxt = 1'b0;
            left_nxt   = byte_data + 8'd1;
          end else begin
            repeat_nxt = 1'b1;
            left_nxt   = byte_data - REPEAT_BIAS;
          end
          idx_nxt    = 2'd0;
          gather_nxt = '0;
        end
      end
      PH_PIXEL: begin
        if (accept) begin
          if (last_byte) begin
            tok_push   = 1'b1;
            idx_nxt    = 2'd0;
            gather_nxt = '0;
            left_nxt   = repeat_r ? 8'd0 : left_r - 8'd1;
          end else begin
            idx_nxt    = idx_r + 2'd1;
            gather_nxt = merged;
          end
        end
      end
      default: tok_push = 1'b0;
    endcase
  end

  assign tok_data.value   = merged;
  assign tok_data.count   = repeat_r ? left_r : 8'd1;
  assign tok_data.end_pkt = pkt_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      repeat_r <= 1'b0;
      left_r   <= '0;
      idx_r    <= '0;
      gather_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      repeat_r <= repeat_nxt;
      left_r   <= left_nxt;
      idx_r    <= idx_nxt;
      gather_r <= gather_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/tgarle_queue.sv =====
// ---------------------------------------------------------------------------
// TGA run-length decoder pixel queue
// Small FIFO of pixel requests between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tgarle_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tgarle_pkg::pix_tok_t push_data,
  output logic                      full,
  input  wire logic                 pop,
  output tgarle_pkg::pix_tok_t      pop_data,
  output logic                      not_empty
);
  import tgarle_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_tok_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/tgarle_back.sv =====
// ---------------------------------------------------------------------------
// TGA run-length decoder back end
// Counts pixels against the image size and issues results.
// ---------------------------------------------------------------------------
`default_nettype none

module tgarle_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [tgarle_pkg::DIM_W-1:0] image_width,
  input  wire logic [tgarle_pkg::DIM_W-1:0] image_height,
  input  wire logic                         tok_valid,
  input  wire tgarle_pkg::pix_tok_t         tok_data,
  output logic                              tok_pop,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic [tgarle_pkg::PIXEL_W-1:0]    res_pixel_value,
  output logic [tgarle_pkg::COUNT_W-1:0]    res_repeat_count,
  output logic                              res_last_of_image,
  output logic                              res_status
);
  import tgarle_pkg::*;

  logic [TOTAL_W-1:0]  total_r;
  logic [TOTAL_W-1:0]  decoded_r, decoded_nxt;
  logic                halted_r, halted_nxt;
  logic                valid_r, valid_nxt;
  logic [PIXEL_W-1:0]  value_r;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                last_r, last_nxt;
  logic                status_r, status_nxt;

  logic [TOTAL_W:0]    diff;
  logic [TOTAL_W-1:0]  remaining;
  logic                overflow;
  logic                exact;
  logic                take;

  assign diff      = {1'b0, total_r} - {1'b0, decoded_r};
  assign remaining = diff[TOTAL_W] ? '0 : diff[TOTAL_W-1:0];
  assign overflow  = (remaining[TOTAL_W-1:COUNT_W] == '0) &&
                     (tok_data.count > remaining[COUNT_W-1:0]);
  assign exact     = (remaining == {{(TOTAL_W-COUNT_W){1'b0}}, tok_data.count});

  assign tok_pop = tok_valid && (halted_r || !valid_r || !res_stall);
  assign take    = tok_pop && !halted_r;

  always_comb begin
    decoded_nxt = decoded_r;
    halted_nxt  = halted_r;
    valid_nxt   = valid_r && res_stall;
    count_nxt   = count_r;
    last_nxt    = last_r;
    status_nxt  = status_r;
    if (take) begin
      valid_nxt = 1'b1;
      if (overflow) begin
        count_nxt  = remaining[COUNT_W-1:0];
        status_nxt = 1'b1;
        last_nxt   = 1'b0;
        halted_nxt = 1'b1;
      end else begin
        count_nxt  = tok_data.count;
        status_nxt = 1'b0;
        last_nxt   = tok_data.end_pkt && exact;
        if (tok_data.end_pkt && exact) begin
          decoded_nxt = '0;
        end else begin
          decoded_nxt = decoded_r + {{(TOTAL_W-COUNT_W){1'b0}}, tok_data.count};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r <= TOTAL_W'(image_width) * TOTAL_W'(image_height);
    if (take) begin
      value_r <= tok_data.value;
    end
    count_r  <= count_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decoded_r <= '0;
      halted_r  <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      decoded_r <= decoded_nxt;
      halted_r  <= halted_nxt;
      valid_r   <= valid_nxt;
    end
  end

  assign res_valid         = valid_r;
  assign res_pixel_value   = value_r;
  assign res_repeat_count  = count_r;
  assign res_last_of_image = last_r;
  assign res_status        = status_r;

endmodule

`default_nettype wire

// ===== design/tga_rle_pixel_decoder.sv =====
// ---------------------------------------------------------------------------
// TGA run-length pixel decoder
// Decodes a run-length pixel stream one byte at a time into pixel results.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  in_stream_byte
//  out_     output     out_valid/out_stall  pixel_value, repeat_count,
//                                           last_of_image, status
//  cfg_     input      cfg_we               cfg_index, cfg_data
//
//  One stream byte is taken per cycle while in_stall is low; the byte that
//  completes a pixel passes from the front end through the pixel queue
//  into the output register, which drives the result.
//  Reset is synchronous and active low; it clears the parse state, the
//  pixel count and the halt flag and loads the register defaults.
//  A stalled output fills the two-entry queue, which then stalls the input.
// ---------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_stream_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [31:0]                            out_pixel_value,
  output logic [7:0]                             out_repeat_count,
  output logic                                   out_last_of_image,
  output logic                                   out_status
);
  import tgarle_pkg::*;

  logic [PB_W-1:0]   pixel_bytes_r;
  logic [DIM_W-1:0]  image_width_r;
  logic [DIM_W-1:0]  image_height_r;

  logic              tok_push;
  pix_tok_t          tok_in;
  logic              tok_full;
  logic              tok_pop;
  pix_tok_t          tok_out;
  logic              tok_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bytes_r  <= PB_RESET;
      image_width_r  <= DIM_RESET;
      image_height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_BYTES:  pixel_bytes_r  <= cfg_data[PB_W-1:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tgarle_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_bytes (pixel_bytes_r),
    .byte_valid  (in_valid),
    .byte_data   (in_stream_byte),
    .byte_stall  (in_stall),
    .tok_push    (tok_push),
    .tok_data    (tok_in),
    .tok_full    (tok_full)
  );

  tgarle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tok_push),
    .push_data (tok_in),
    .full      (tok_full),
    .pop       (tok_pop),
    .pop_data  (tok_out),
    .not_empty (tok_valid)
  );

  tgarle_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .image_width       (image_width_r),
    .image_height      (image_height_r),
    .tok_valid         (tok_valid),
    .tok_data          (tok_out),
    .tok_pop           (tok_pop),
    .res_valid         (out_valid),
    .res_stall         (out_stall),
    .res_pixel_value   (out_pixel_value),
    .res_repeat_count  (out_repeat_count),
    .res_last_of_image (out_last_of_image),
    .res_status        (out_status)
  );

endmodule

`default_nettype wire
